// File: hw/rtl/lazy_range_add_range_sum_tree_defines.svh
// Assertion macros shared by the checker of the range-add range-sum tree.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef LAZY_RANGE_ADD_RANGE_SUM_TREE_DEFINES_SVH
`define LAZY_RANGE_ADD_RANGE_SUM_TREE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LRST_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lrst: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LRST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lrst: next-cycle check failed");

`endif

// File: hw/rtl/lrst_pkg.sv
// Package of the range-add range-sum tree: command codes and size defaults.
// No dependencies; used by the top level, lrst_seq and lrst_chk.
`default_nettype none

package lrst_pkg;

    localparam int unsigned LRST_LEAVES = 1024;
    localparam int unsigned LRST_NODES  = 4096;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

endpackage

`default_nettype wire

// File: hw/rtl/lazy_range_add_range_sum_tree.sv
// Range-add range-sum tree, top level: size register, sequencer and node RAM.
// Depends on lrst_pkg, lrst_seq and lrst_ram.
//
// Input channel i_in_valid/o_in_ready carries one command per transaction:
// range add, range sum query, clear all. Output channel o_out_valid/
// i_out_ready returns one result per query and per rejected range.
// A range add walks the tree and updates node sums and tags in the RAM;
// a query accumulates sums with the tags of the nodes above.
// Each visited node is read from the RAM (S_POP), multiplied (S_CALC) and
// applied (S_APPLY), written back for an add; a command visits up to about
// 4 nodes per level. An invalid range goes straight to the result without
// walking the tree. Commands are handled one at a time.
// Reset, clear and any write of i_cfg_data start a sweep zeroing all NODES
// entries of the RAM; o_in_ready stays low meanwhile.
// A finished result waits in the output register; the next command is
// accepted meanwhile, and a new result waits until that register is taken.
`default_nettype none

module lazy_range_add_range_sum_tree
    import lrst_pkg::*;
#(
    parameter int unsigned LEAVES = LRST_LEAVES,
    parameter int unsigned NODES  = LRST_NODES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [10:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_command,
    input  wire logic [9:0]         i_range_left,
    input  wire logic [9:0]         i_range_right,
    input  wire logic signed [31:0] i_add_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [63:0]      o_range_sum,
    output logic                    o_range_error
);

    localparam int unsigned CW = $clog2(LEAVES) + 1;
    localparam int unsigned KW = $clog2(NODES);

    logic [CW-1:0]  r_size, n_size;
    logic [31:0]    cfg_ext;
    logic           mem_we, mem_re;
    logic [KW-1:0]  mem_waddr, mem_raddr;
    logic [127:0]   mem_wdata, mem_rdata;

    assign cfg_ext = 32'(i_cfg_data);

    always_comb begin
        if (cfg_ext == 32'd0) begin
            n_size = CW'(1);
        end else if (cfg_ext > 32'(LEAVES)) begin
            n_size = CW'(LEAVES);
        end else begin
            n_size = CW'(cfg_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= CW'(LEAVES);
        end else if (i_cfg_we) begin
            r_size <= n_size;
        end
    end

    lrst_seq #(
        .LEAVES (LEAVES),
        .NODES  (NODES)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clr         (i_cfg_we),
        .i_size        (r_size),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_range_left  (i_range_left),
        .i_range_right (i_range_right),
        .i_add_value   (i_add_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_range_sum   (o_range_sum),
        .o_range_error (o_range_error),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_re      (mem_re),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

    lrst_ram #(
        .DEPTH (NODES),
        .WIDTH (128)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// File: hw/rtl/lrst_ram.sv
// Simple dual-port synchronous RAM holding node sums and node tags.
// One write and one read per cycle, registered read data. No dependencies.
`default_nettype none

module lrst_ram #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned WIDTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lrst_seq.sv
// Tree walk sequencer: node stack, read-modify-write of the node RAM,
// clearing sweep and result register. Depends on lrst_pkg.
`default_nettype none

module lrst_seq
    import lrst_pkg::*;
#(
    parameter int unsigned LEAVES = LRST_LEAVES,
    parameter int unsigned NODES  = LRST_NODES
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_clr,
    input  wire logic [$clog2(LEAVES):0]    i_size,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [1:0]                 i_command,
    input  wire logic [9:0]                 i_range_left,
    input  wire logic [9:0]                 i_range_right,
    input  wire logic signed [31:0]         i_add_value,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic signed [63:0]              o_range_sum,
    output logic                            o_range_error,
    output logic                            o_mem_we,
    output logic [$clog2(NODES)-1:0]        o_mem_waddr,
    output logic [127:0]                    o_mem_wdata,
    output logic                            o_mem_re,
    output logic [$clog2(NODES)-1:0]        o_mem_raddr,
    input  wire logic [127:0]               i_mem_rdata
);

    localparam int unsigned IW  = $clog2(LEAVES);
    localparam int unsigned CW  = IW + 1;
    localparam int unsigned KW  = $clog2(NODES);
    localparam int unsigned SD  = IW + 2;
    localparam int unsigned TW  = $clog2(SD);
    localparam int unsigned SPW = $clog2(SD + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_POP   = 6'b000100,
        S_CALC  = 6'b001000,
        S_APPLY = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [KW-1:0]  r_clr;
    logic [SPW-1:0] r_sp;
    logic [KW-1:0]  r_stk_k   [SD];
    logic [IW-1:0]  r_stk_lo  [SD];
    logic [IW-1:0]  r_stk_hi  [SD];
    logic [63:0]    r_stk_acc [SD];

    logic [KW-1:0]  r_k;
    logic [IW-1:0]  r_lo, r_hi;
    logic [63:0]    r_acc;
    logic [IW-1:0]  r_l, r_r;
    logic [63:0]    r_v;
    logic           r_is_add;
    logic [63:0]    r_prod;
    logic [63:0]    r_res;
    logic           r_err;

    logic [TW-1:0]  top;
    logic [IW-1:0]  mx, mn, mid, mid_p1;
    logic [IW:0]    lohi;
    logic [CW-1:0]  ov;
    logic           full, has_l, has_r;
    logic [63:0]    node_sum, node_tag, child_acc;
    logic [KW-1:0]  k_l, k_r;
    logic           bad, accept, emit_go;

    assign top    = TW'(r_sp - SPW'(1));
    assign mx     = (r_l > r_lo) ? r_l : r_lo;
    assign mn     = (r_r < r_hi) ? r_r : r_hi;
    assign ov     = {1'b0, mn} - {1'b0, mx} + CW'(1);
    assign full   = (r_l <= r_lo) && (r_hi <= r_r);
    assign lohi   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid    = lohi[IW:1];
    assign mid_p1 = mid + IW'(1);
    assign has_l  = (r_l <= mid);
    assign has_r  = (r_r > mid);
    assign k_l    = {r_k[KW-2:0], 1'b0};
    assign k_r    = {r_k[KW-2:0], 1'b1};
    assign node_sum  = i_mem_rdata[127:64];
    assign node_tag  = i_mem_rdata[63:0];
    assign child_acc = r_is_add ? 64'd0 : (r_acc + node_tag);

    assign bad = (i_range_left > i_range_right)
              || (32'(i_range_right) >= 32'(i_size));
    assign o_in_ready = (r_state == S_IDLE) && !i_clr;
    assign accept     = i_in_valid && o_in_ready;
    assign emit_go    = !o_out_valid || i_out_ready;

    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_k;
        o_mem_wdata = '0;
        if (r_state == S_CLEAR) begin
            o_mem_we    = 1'b1;
            o_mem_waddr = r_clr;
        end else if (r_state == S_APPLY && r_is_add) begin
            o_mem_we    = 1'b1;
            o_mem_wdata = {node_sum + r_prod, full ? (node_tag + r_v) : node_tag};
        end
    end

    assign o_mem_re    = (r_state == S_POP) && (r_sp != '0);
    assign o_mem_raddr = r_stk_k[top];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_command))
                        CMD_CLEAR: n_state = S_CLEAR;
                        CMD_ADD, CMD_QUERY: n_state = bad ? S_EMIT : S_POP;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                if (r_clr == KW'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_state = r_is_add ? S_IDLE : S_EMIT;
                end else begin
                    n_state = S_CALC;
                end
            end
            S_CALC:  n_state = S_APPLY;
            S_APPLY: n_state = S_POP;
            S_EMIT: begin
                if (emit_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_clr) begin
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_sp        <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_clr || (accept && t_cmd'(i_command) == CMD_CLEAR)) begin
                r_clr <= '0;
            end else if (r_state == S_CLEAR) begin
                r_clr <= r_clr + KW'(1);
            end
            if (accept) begin
                r_sp <= SPW'(1);
            end else if (r_state == S_POP && r_sp != '0) begin
                r_sp <= r_sp - SPW'(1);
            end else if (r_state == S_APPLY && !full) begin
                r_sp <= r_sp + SPW'(has_l) + SPW'(has_r);
            end
            if (r_state == S_EMIT && emit_go) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_l          <= IW'(i_range_left);
            r_r          <= IW'(i_range_right);
            r_v          <= {{32{i_add_value[31]}}, i_add_value};
            r_is_add     <= (t_cmd'(i_command) == CMD_ADD);
            r_err        <= bad;
            r_res        <= '0;
            r_stk_k[0]   <= KW'(1);
            r_stk_lo[0]  <= '0;
            r_stk_hi[0]  <= IW'(i_size - CW'(1));
            r_stk_acc[0] <= '0;
        end
        if (r_state == S_POP && r_sp != '0) begin
            r_k   <= r_stk_k[top];
            r_lo  <= r_stk_lo[top];
            r_hi  <= r_stk_hi[top];
            r_acc <= r_stk_acc[top];
        end
        if (r_state == S_CALC) begin
            r_prod <= 64'((r_is_add ? r_v : r_acc) * ov);
        end
        if (r_state == S_APPLY) begin
            if (full) begin
                if (!r_is_add) begin
                    r_res <= r_res + node_sum + r_prod;
                end
            end else if (has_l && has_r) begin
                r_stk_k[TW'(r_sp)]   <= k_r;
                r_stk_lo[TW'(r_sp)]  <= mid_p1;
                r_stk_hi[TW'(r_sp)]  <= r_hi;
                r_stk_acc[TW'(r_sp)] <= child_acc;
                r_stk_k[TW'(r_sp + SPW'(1))]   <= k_l;
                r_stk_lo[TW'(r_sp + SPW'(1))]  <= r_lo;
                r_stk_hi[TW'(r_sp + SPW'(1))]  <= mid;
                r_stk_acc[TW'(r_sp + SPW'(1))] <= child_acc;
            end else if (has_l) begin
                r_stk_k[TW'(r_sp)]   <= k_l;
                r_stk_lo[TW'(r_sp)]  <= r_lo;
                r_stk_hi[TW'(r_sp)]  <= mid;
                r_stk_acc[TW'(r_sp)] <= child_acc;
            end else begin
                r_stk_k[TW'(r_sp)]   <= k_r;
                r_stk_lo[TW'(r_sp)]  <= mid_p1;
                r_stk_hi[TW'(r_sp)]  <= r_hi;
                r_stk_acc[TW'(r_sp)] <= child_acc;
            end
        end
        if (r_state == S_EMIT && emit_go) begin
            o_range_sum   <= r_err ? 64'sd0 : r_res;
            o_range_error <= r_err;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lrst_chk.sv
// Port-level checker of the range-add range-sum tree, bound to the top level.
// Depends on lrst_pkg and lazy_range_add_range_sum_tree_defines.svh.
`default_nettype none

`include "lazy_range_add_range_sum_tree_defines.svh"

module lrst_chk
    import lrst_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_cfg_we,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic [1:0]  i_command,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] o_range_sum,
    input wire logic        o_range_error
);

    `LRST_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `LRST_ASSERT_IMP(a_err_zero, o_out_valid && o_range_error, o_range_sum == 64'd0)
    `LRST_ASSERT_NEXT(a_cfg_sweep, i_cfg_we, !o_in_ready)
    `LRST_ASSERT_NEXT(a_clr_sweep, i_in_valid && o_in_ready && i_command == CMD_CLEAR, !o_in_ready)

endmodule

bind lazy_range_add_range_sum_tree lrst_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_command     (i_command),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_range_sum   (o_range_sum),
    .o_range_error (o_range_error)
);

`default_nettype wire
